### design/ssirm_pkg.sv
`default_nettype none

package ssirm_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 16;

   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type KIND_INSERT = 2'd0;
   localparam kind_type KIND_REMOVE = 2'd1;
   localparam kind_type KIND_DUMP   = 2'd2;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INSERT,
      OP_REMOVE,
      OP_DUMP,
      OP_REPLY
   } op_type;

   typedef struct packed {
      op_type     op;
      status_type status;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } flags_type;

endpackage

`default_nettype wire

### design/ssirm_ctrl.sv
`default_nettype none

module ssirm_ctrl #(
   parameter int DEPTH = ssirm_pkg::DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire ssirm_pkg::kind_type  req_kind,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ssirm_pkg::flags_type flags,
   input  wire logic [CNT_W-1:0]     count,
   output      ssirm_pkg::cmd_type   cmd,
   output      logic [IDX_W-1:0]     rd_idx
);
   import ssirm_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_DUMP
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             accept;
   logic [CNT_W-1:0] count_m1;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign count_m1  = count - CNT_W'(1);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      cmd.op     = OP_NOP;
      cmd.status = STATUS_OK;
      cmd.last   = 1'b1;
      rd_idx     = count_m1[IDX_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_INSERT: begin
                     if (flags.full) begin
                        cmd.op     = OP_REPLY;
                        cmd.status = STATUS_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                     end
                  end
                  KIND_REMOVE: begin
                     if (flags.empty) begin
                        cmd.op     = OP_REPLY;
                        cmd.status = STATUS_EMPTY;
                     end else begin
                        cmd.op = OP_REMOVE;
                     end
                  end
                  KIND_DUMP: begin
                     if (flags.empty) begin
                        cmd.op     = OP_REPLY;
                        cmd.status = STATUS_EMPTY;
                     end else begin
                        state_in = ST_DUMP;
                        idx_in   = '0;
                     end
                  end
                  default: begin
                     cmd.op = OP_REPLY;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               cmd.op   = OP_DUMP;
               rd_idx   = idx_ff;
               cmd.last = (idx_ff == count_m1[IDX_W-1:0]);
               idx_in   = IDX_W'(idx_ff + 1'b1);
               if (cmd.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.op != OP_NOP) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### design/ssirm_dpath.sv
`default_nettype none

module ssirm_dpath #(
   parameter int DEPTH      = ssirm_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = ssirm_pkg::DATA_WIDTH_DEF,
   parameter int IDX_W      = $clog2(DEPTH),
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   input  wire ssirm_pkg::cmd_type     cmd,
   input  wire logic [IDX_W-1:0]       rd_idx,
   output      ssirm_pkg::flags_type   flags,
   output      logic [CNT_W-1:0]       count,
   output      logic signed [DATA_WIDTH-1:0] rsp_value_res,
   output      logic [CNT_W-1:0]       rsp_count,
   output      ssirm_pkg::status_type  rsp_status,
   output      logic                   rsp_last
);
   import ssirm_pkg::*;

   logic signed [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic signed [DATA_WIDTH-1:0] store_in [DEPTH];
   logic        [DEPTH-1:0]      gt;
   logic        [CNT_W-1:0]      count_ff, count_in;
   logic signed [DATA_WIDTH-1:0] rd_data;
   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic        [CNT_W-1:0]      rsp_count_ff;
   status_type                   status_ff;
   logic                         last_ff;

   assign count       = count_ff;
   assign flags.full  = (count_ff == CNT_W'(DEPTH));
   assign flags.empty = (count_ff == '0);
   assign rd_data     = store_ff[rd_idx];

   // insert slot: first held entry above the new word
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (store_ff[i] > req_value);
      end
      for (int i = 0; i < DEPTH; i++) begin
         store_in[i] = store_ff[i];
         if (gt[i] || CNT_W'(i) == count_ff) begin
            store_in[i] = req_value;
         end
      end
      for (int i = 1; i < DEPTH; i++) begin
         if (gt[i-1]) begin
            store_in[i] = store_ff[i-1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      value_in = '0;
      case (cmd.op)
         OP_INSERT: count_in = CNT_W'(count_ff + 1'b1);
         OP_REMOVE: begin
            count_in = CNT_W'(count_ff - 1'b1);
            value_in = rd_data;
         end
         OP_DUMP:   value_in = rd_data;
         default:   value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_INSERT) begin
         store_ff <= store_in;
      end
      if (cmd.op != OP_NOP) begin
         value_ff     <= value_in;
         rsp_count_ff <= count_in;
         status_ff    <= cmd.status;
         last_ff      <= cmd.last;
      end
   end

   assign rsp_value_res = value_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

### design/sorted_store_insert_remove_max.sv
`default_nettype none

// Sorted store of up to DEPTH signed words kept in ascending order in a row of
// registers. For an insert (kind 0) every entry compares itself with the new
// word in parallel and those above it shift up one place; remove-largest
// (kind 1) takes the largest word, which sits at the top of the held run. A
// dump (kind 2) emits one word per cycle while the output is not stalled,
// smallest first, and holds off new requests until its last word is issued;
// rsp_last marks the final word of every reply. Results pass through an output
// register, so a new request is taken in the cycle that the waiting word
// leaves, but not during a dump. No clearing pass after reset.
module sorted_store_insert_remove_max #(
   parameter int DEPTH      = ssirm_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = ssirm_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire ssirm_pkg::kind_type          req_kind,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic signed [DATA_WIDTH-1:0] rsp_value_res,
   output      logic [$clog2(DEPTH+1)-1:0]   rsp_count,
   output      ssirm_pkg::status_type        rsp_status,
   output      logic                         rsp_last
);
   import ssirm_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          cmd;
   flags_type        flags;
   logic [CNT_W-1:0] count;
   logic [IDX_W-1:0] rd_idx;

   ssirm_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .count     (count),
      .cmd       (cmd),
      .rd_idx    (rd_idx)
   );

   ssirm_dpath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .rd_idx        (rd_idx),
      .flags         (flags),
      .count         (count),
      .rsp_value_res (rsp_value_res),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

### bench/sorted_store_insert_remove_max_test.sv
`timescale 1ns / 100ps

module sorted_store_insert_remove_max_test;
   import ssirm_pkg::*;

   localparam int DEPTH         = 16;
   localparam int DW            = 16;
   localparam int CW            = $clog2(DEPTH + 1);
   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SEGMENT_LEN   = 24;
   localparam kind_type KIND_SPARE = 2'd3;

   typedef struct packed {
      kind_type               kind;
      logic signed [DW-1:0]   value;
   } store_op_type;

   typedef struct packed {
      logic signed [DW-1:0]   value_res;
      logic [CW-1:0]          count;
      status_type             status;
      logic                   last;
   } reply_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   kind_type             req_kind = KIND_INSERT;
   logic signed [DW-1:0] req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [DW-1:0] rsp_value_res;
   logic [CW-1:0]        rsp_count;
   status_type           rsp_status;
   logic                 rsp_last;

   store_op_type         pending_ops[$];
   reply_type            expected_replies[$];
   logic signed [DW-1:0] held_values[$];
   store_op_type         next_op;
   logic                 req_taken = 1'b0;
   int                   idle_pct = 0;
   int                   stall_pct = 0;
   int                   mismatches = 0;
   int                   quiet_cycles = 0;
   int                   phase;

   sorted_store_insert_remove_max #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DW)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_count     (rsp_count),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic queue_op(input kind_type k, input logic signed [DW-1:0] v);
      store_op_type op;
      op.kind  = k;
      op.value = v;
      pending_ops.push_back(op);
   endtask

   function automatic reply_type make_reply(input logic signed [DW-1:0] v, input status_type s,
                                            input logic l);
      reply_type r;
      r.value_res = v;
      r.count     = CW'(held_values.size());
      r.status    = s;
      r.last      = l;
      return r;
   endfunction

   // keeps held_values ascending; equal values go above existing ones
   task automatic apply_store_op(input kind_type k, input logic signed [DW-1:0] v);
      int                   pos;
      int                   i;
      logic signed [DW-1:0] top;
      case (k)
         KIND_INSERT: begin
            if (held_values.size() >= DEPTH) begin
               expected_replies.push_back(make_reply('0, STATUS_FULL, 1'b1));
            end else begin
               pos = held_values.size();
               while (pos > 0 && held_values[pos-1] > v)
                  pos--;
               held_values.insert(pos, v);
               expected_replies.push_back(make_reply('0, STATUS_OK, 1'b1));
            end
         end
         KIND_REMOVE: begin
            if (held_values.size() == 0) begin
               expected_replies.push_back(make_reply('0, STATUS_EMPTY, 1'b1));
            end else begin
               top = held_values.pop_back();
               expected_replies.push_back(make_reply(top, STATUS_OK, 1'b1));
            end
         end
         KIND_DUMP: begin
            if (held_values.size() == 0) begin
               expected_replies.push_back(make_reply('0, STATUS_EMPTY, 1'b1));
            end else begin
               for (i = 0; i < held_values.size(); i++)
                  expected_replies.push_back(make_reply(held_values[i], STATUS_OK,
                                                        i == held_values.size() - 1));
            end
         end
         default: begin
            expected_replies.push_back(make_reply('0, STATUS_OK, 1'b1));
         end
      endcase
   endtask

   task automatic compare_reply;
      reply_type want;
      if (expected_replies.size() == 0) begin
         $error("unexpected word: value_res %0d count %0d status %0d last %0d",
                rsp_value_res, rsp_count, rsp_status, rsp_last);
         mismatches++;
      end else begin
         want = expected_replies.pop_front();
         if (rsp_value_res !== want.value_res) begin
            $error("value_res: expected %0d, got %0d", $signed(want.value_res), rsp_value_res);
            mismatches++;
         end
         if (rsp_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, rsp_count);
            mismatches++;
         end
         if (rsp_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_status);
            mismatches++;
         end
         if (rsp_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp_last);
            mismatches++;
         end
      end
   endtask

   // fill, drain and mixed stretches so the store sweeps empty to full
   task automatic random_ops(input int n);
      int                   i;
      int                   mode;
      int                   insert_pct;
      int                   r;
      kind_type             k;
      logic signed [DW-1:0] v;
      mode = 0;
      for (i = 0; i < n; i++) begin
         if (i % SEGMENT_LEN == 0)
            mode = $urandom_range(2);
         insert_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
         r = $urandom_range(99);
         if (r < 7)
            k = KIND_DUMP;
         else if (r < 10)
            k = KIND_SPARE;
         else if ($urandom_range(99) < insert_pct)
            k = KIND_INSERT;
         else
            k = KIND_REMOVE;
         case ($urandom_range(9))
            0: begin
               case ($urandom_range(3))
                  0: v = 16'h7fff;
                  1: v = 16'h8000;
                  2: v = 16'h0000;
                  default: v = 16'hffff;
               endcase
            end
            1, 2, 3: v = DW'($urandom_range(8)) - DW'(4);
            default: v = DW'($urandom);
         endcase
         queue_op(k, v);
      end
   endtask

   task automatic drain_wait;
      do
         @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_replies.size() != 0);
   endtask

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_op = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_kind  <= next_op.kind;
            req_value <= next_op.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_taken    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready)
            compare_reply();
         if (req_valid && req_ready)
            apply_store_op(req_kind, req_value);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (pending_ops.size() == 0 && !req_valid && expected_replies.size() == 0))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store
      queue_op(KIND_SPARE, 16'h7fff);
      queue_op(KIND_REMOVE, 16'h8000);
      queue_op(KIND_DUMP, 16'hffff);
      // fill to the brim, with extremes and repeats
      queue_op(KIND_INSERT, 16'h7fff);
      queue_op(KIND_INSERT, 16'h8000);
      queue_op(KIND_INSERT, 16'h0000);
      queue_op(KIND_INSERT, 16'hffff);
      queue_op(KIND_INSERT, 16'h0001);
      queue_op(KIND_INSERT, 16'h0000);
      queue_op(KIND_INSERT, 16'h0000);
      queue_op(KIND_INSERT, 16'h5555);
      queue_op(KIND_INSERT, 16'haaaa);
      queue_op(KIND_INSERT, 16'h7fff);
      queue_op(KIND_INSERT, 16'h8000);
      queue_op(KIND_INSERT, 16'h0064);
      queue_op(KIND_INSERT, 16'hff9c);
      queue_op(KIND_INSERT, 16'h7ffe);
      queue_op(KIND_INSERT, 16'h8001);
      queue_op(KIND_INSERT, 16'h1234);
      // full store
      queue_op(KIND_INSERT, 16'hfff9);
      queue_op(KIND_DUMP, 16'h0000);
      queue_op(KIND_SPARE, 16'h8000);
      queue_op(KIND_REMOVE, 16'h0000);
      queue_op(KIND_REMOVE, 16'h7fff);
      drain_wait();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 46;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 46;
            end
            default: begin
               idle_pct  = 24;
               stall_pct = 24;
            end
         endcase
         random_ops(82);
         drain_wait();
      end

      stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
